>>> design/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal text block.
// No dependencies; the top level, converter and emitter refer to this package by scope.
package sitda_pkg;

    localparam int DIGIT_BITS = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Shift-and-add-3 correction: a BCD digit of five or more gets three added
    localparam logic [DIGIT_BITS-1:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_BITS-1:0] DIGIT_ADJ     = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } conv_state_t;

    typedef struct packed {
        logic start;
        logic neg;
    } emit_cmd_t;

endpackage

>>> design/sitda_in_if.sv
// Input channel: valid/ready handshake carrying one signed integer per beat.
// No dependencies.
interface sitda_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> design/sitda_out_if.sv
// Output channel: valid/ready handshake carrying one ASCII character per beat.
// No dependencies.
interface sitda_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

>>> design/signed_int_to_decimal_ascii.sv
// Top level: signed integer in, decimal ASCII text out, one character per beat.
// Depends on sitda_pkg, sitda_in_if, sitda_out_if, sitda_bcd_conv, sitda_char_emit.
//
// Each accepted value is turned into its magnitude, converted to BCD by a
// shift-and-add-3 loop that takes one magnitude bit per cycle, then sent out
// as text: '-' for a negative value, then the digits most significant first,
// one BCD digit examined per cycle while the output register is free, leading
// zeros dropped and last_char set on the final digit. The block takes a new
// value only once the emitter has examined the final digit of the previous one
// and the control has gone back to idle; it does not overlap values.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    sitda_in_if.sink    value_ch,
    sitda_out_if.source char_ch
);

    // decimal digits of the largest magnitude, 2^(VALUE_BITS-1)
    localparam int DIGITS = (VALUE_BITS - 1) * 30103 / 100000 + 1;
    localparam int BCD_W  = DIGITS * sitda_pkg::DIGIT_BITS;

    sitda_pkg::conv_state_t state_reg, state_next;
    sitda_pkg::emit_cmd_t   cmd;

    logic                  neg_reg, neg_next;
    logic                  accept;
    logic                  conv_load;
    logic                  conv_done;
    logic                  emit_busy;
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic [BCD_W-1:0]      bcd;

    assign accept = value_ch.valid && value_ch.ready;
    assign raw    = $unsigned(value_ch.value);
    assign mag    = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sitda_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sitda_pkg::ST_CONV;
                end
            end
            sitda_pkg::ST_CONV:
            begin
                if (conv_done)
                begin
                    state_next = sitda_pkg::ST_EMIT;
                end
            end
            sitda_pkg::ST_EMIT:
            begin
                if (!emit_busy)
                begin
                    state_next = sitda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sitda_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        value_ch.ready = 1'b0;
        conv_load      = 1'b0;
        cmd.start      = 1'b0;
        cmd.neg        = neg_reg;
        neg_next       = neg_reg;
        case (state_reg)
            sitda_pkg::ST_IDLE:
            begin
                value_ch.ready = 1'b1;
                conv_load      = accept;
                if (accept)
                begin
                    neg_next = raw[VALUE_BITS-1];
                end
            end
            sitda_pkg::ST_CONV:
            begin
                cmd.start = conv_done;
            end
            sitda_pkg::ST_EMIT:
            begin
                cmd.start = 1'b0;
            end
            default:
            begin
                value_ch.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sitda_pkg::ST_IDLE;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            neg_reg   <= neg_next;
        end
    end

    sitda_bcd_conv #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (conv_load),
        .mag   (mag),
        .done  (conv_done),
        .bcd   (bcd)
    );

    sitda_char_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .bcd     (bcd),
        .busy    (emit_busy),
        .char_ch (char_ch)
    );

    a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> state_reg == sitda_pkg::ST_CONV)
        else $error("converter finished outside the conversion phase");

    a_idle_emit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sitda_pkg::ST_IDLE |-> !emit_busy)
        else $error("emitter still busy while taking a new value");

    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == sitda_pkg::ST_CONV)
        else $error("accepted value did not start a conversion");

endmodule

>>> design/sitda_bcd_conv.sv
// Bit-serial binary to BCD converter (shift-and-add-3), one magnitude bit per cycle.
// Depends on sitda_pkg.
module sitda_bcd_conv #(
    parameter int VALUE_BITS = 32,
    parameter int DIGITS     = 10
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  logic [VALUE_BITS-1:0]                   mag,
    output logic                                    done,
    output logic [DIGITS*sitda_pkg::DIGIT_BITS-1:0] bcd
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int BCD_W = DIGITS * sitda_pkg::DIGIT_BITS;

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [BCD_W-1:0]      adj;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    // Correct every digit before the shift; digits are independent
    always_comb
    begin
        logic [sitda_pkg::DIGIT_BITS-1:0] d;
        d = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            d = bcd_reg[i*sitda_pkg::DIGIT_BITS +: sitda_pkg::DIGIT_BITS];
            adj[i*sitda_pkg::DIGIT_BITS +: sitda_pkg::DIGIT_BITS] =
                (d >= sitda_pkg::DIGIT_ADJ_MIN) ? d + sitda_pkg::DIGIT_ADJ : d;
        end
    end

    always_comb
    begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (load)
        begin
            mag_next  = mag;
            bcd_next  = '0;
            cnt_next  = CNT_W'(VALUE_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
            mag_next = mag_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

>>> design/sitda_char_emit.sv
// Character emitter: sends the sign, then BCD digits one per cycle while the
// output register is free, no leading zeros. Uses sitda_pkg, sitda_out_if.
module sitda_char_emit #(
    parameter int DIGITS = 10
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  sitda_pkg::emit_cmd_t                    cmd,
    input  logic [DIGITS*sitda_pkg::DIGIT_BITS-1:0] bcd,
    output logic                                    busy,
    sitda_out_if.source                             char_ch
);

    localparam int BCD_W  = DIGITS * sitda_pkg::DIGIT_BITS;
    localparam int LEFT_W = $clog2(DIGITS + 1);

    logic [BCD_W-1:0]                 dig_reg, dig_next;
    logic [LEFT_W-1:0]                left_reg, left_next;
    logic                             sign_reg, sign_next;
    logic                             started_reg, started_next;
    logic                             busy_reg, busy_next;
    logic                             out_valid_reg, out_valid_next;
    logic [7:0]                       char_reg, char_next;
    logic                             last_reg, last_next;
    logic                             free;
    logic                             load;
    logic                             is_last;
    logic [sitda_pkg::DIGIT_BITS-1:0] top_digit;

    assign free      = !out_valid_reg || char_ch.ready;
    assign top_digit = dig_reg[BCD_W-1 -: sitda_pkg::DIGIT_BITS];
    assign is_last   = (left_reg == LEFT_W'(1));

    always_comb
    begin
        dig_next     = dig_reg;
        left_next    = left_reg;
        sign_next    = sign_reg;
        started_next = started_reg;
        busy_next    = busy_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        load         = 1'b0;
        if (cmd.start)
        begin
            dig_next     = bcd;
            left_next    = LEFT_W'(DIGITS);
            sign_next    = cmd.neg;
            started_next = 1'b0;
            busy_next    = 1'b1;
        end
        else if (busy_reg && free)
        begin
            if (sign_reg)
            begin
                char_next = sitda_pkg::CHAR_MINUS;
                last_next = 1'b0;
                load      = 1'b1;
                sign_next = 1'b0;
            end
            else
            begin
                dig_next  = dig_reg << sitda_pkg::DIGIT_BITS;
                left_next = left_reg - LEFT_W'(1);
                // drop leading zeros, but always send the units digit
                if (top_digit != '0 || started_reg || is_last)
                begin
                    char_next    = sitda_pkg::CHAR_ZERO + 8'(top_digit);
                    last_next    = is_last;
                    load         = 1'b1;
                    started_next = 1'b1;
                end
                if (is_last)
                begin
                    busy_next = 1'b0;
                end
            end
        end
        out_valid_next = load ? 1'b1 : (char_ch.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            sign_reg      <= 1'b0;
            started_reg   <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            sign_reg      <= sign_next;
            started_reg   <= started_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy              = busy_reg;
    assign char_ch.valid     = out_valid_reg;
    assign char_ch.char_code = char_reg;
    assign char_ch.last_char = last_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg)
        else $error("emitter restarted while busy");

    a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && sign_reg |-> !started_reg)
        else $error("digit sent before the sign");

    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> left_reg != '0)
        else $error("emitter busy with no digits left");

endmodule
